/* src/cbdc_pkg.sv */
package cbdc_pkg;

    // Widths of the request and result fields
    localparam int unsigned META_W  = 64;
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned PERM_W  = 12;
    localparam int unsigned UPERM_W = 4;
    localparam int unsigned OTYPE_W = 18;
    localparam int unsigned EXP_W   = 6;
    localparam int unsigned MANT_W  = 14;

    // Stored metadata is XORed with the null capability pattern
    localparam logic [META_W-1:0] NULL_MASK = 64'h0000_1fff_fc01_8004;

    // Permission bits checked on access
    localparam int unsigned PERM_STORE_BIT = 8;
    localparam int unsigned PERM_LOAD_BIT  = 9;

    // Decoded metadata handed from the decoder to the bounds stage
    typedef struct packed {
        logic [PERM_W-1:0]  perms;
        logic [UPERM_W-1:0] uperms;
        logic [OTYPE_W-1:0] otype;
        logic [EXP_W-1:0]   exp;
        logic [MANT_W-1:0]  top_mant;
        logic [MANT_W-1:0]  base_mant;
    } t_dec;

endpackage

/* src/cbdc_decode.sv */
module cbdc_decode
    import cbdc_pkg::*;
(
    input  logic [META_W-1:0] i_meta,
    output t_dec              o_dec
);

    logic [META_W-1:0] meta;
    logic              int_exp;
    logic [8:0]        t_hi;
    logic [2:0]        t_e;
    logic [10:0]       b_hi;
    logic [2:0]        b_e;
    logic [11:0]       t_low;
    logic [MANT_W-1:0] b_mant;
    logic              carry;
    logic              msb;
    logic [1:0]        t_top2;

    assign meta    = i_meta ^ NULL_MASK;
    assign int_exp = meta[26];
    assign t_hi    = meta[25:17];
    assign t_e     = meta[16:14];
    assign b_hi    = meta[13:3];
    assign b_e     = meta[2:0];

    // Mantissas: low exponent bits are mantissa when there is no internal exponent
    always_comb begin
        if (int_exp) begin
            t_low  = {t_hi, 3'b000};
            b_mant = {b_hi, 3'b000};
            carry  = (t_hi < b_hi[8:0]);
            msb    = 1'b1;
        end else begin
            t_low  = {t_hi, t_e};
            b_mant = {b_hi, b_e};
            carry  = (t_low < b_mant[11:0]);
            msb    = 1'b0;
        end
    end

    // Top two bits of top mantissa come from base plus carry and length msb
    assign t_top2 = b_mant[13:12] + {1'b0, carry} + {1'b0, msb};

    assign o_dec.perms     = meta[63:52];
    assign o_dec.uperms    = meta[51:48];
    assign o_dec.otype     = meta[44:27];
    assign o_dec.exp       = int_exp ? {t_e, b_e} : '0;
    assign o_dec.top_mant  = {t_top2, t_low};
    assign o_dec.base_mant = b_mant;

endmodule

/* src/cbdc_bounds.sv */
module cbdc_bounds
    import cbdc_pkg::*;
(
    input  t_dec              i_dec,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [LEN_W-1:0]  i_len,
    input  logic              i_rd,
    input  logic              i_wr,
    output logic [ADDR_W-1:0] o_base,
    output logic [ADDR_W-1:0] o_top,
    output logic              o_ok
);

    logic [ADDR_W-12:0] addr_sh11;
    logic [ADDR_W-15:0] addr_sh14;
    logic [ADDR_W-12:0] a_sh;
    logic [ADDR_W-1:0]  a_top;
    logic [2:0]         a3;
    logic [2:0]         t3;
    logic [2:0]         b3;
    logic [2:0]         r;
    logic               a_lo;
    logic               t_lo;
    logic               b_lo;
    logic [ADDR_W-1:0]  t_hi_part;
    logic [ADDR_W-1:0]  b_hi_part;
    logic [EXP_W:0]     hi_shift;
    logic [ADDR_W-1:0]  end_addr;

    // Address slices above the mantissa window; exponents past the width give zero
    assign addr_sh11 = i_addr[ADDR_W-1:11];
    assign addr_sh14 = i_addr[ADDR_W-1:14];
    assign a_sh      = addr_sh11 >> i_dec.exp;
    assign a3        = a_sh[2:0];
    assign a_top     = ADDR_W'(addr_sh14 >> i_dec.exp);

    // Region compare against the representable limit r
    assign t3   = i_dec.top_mant[13:11];
    assign b3   = i_dec.base_mant[13:11];
    assign r    = b3 - 3'd1;
    assign a_lo = (a3 < r);
    assign t_lo = (t3 < r);
    assign b_lo = (b3 < r);

    // Correct the upper address bits by -1, 0 or +1
    always_comb begin
        t_hi_part = a_top;
        if (a_lo && !t_lo) begin
            t_hi_part = a_top - ADDR_W'(1);
        end else if (!a_lo && t_lo) begin
            t_hi_part = a_top + ADDR_W'(1);
        end
        b_hi_part = a_top;
        if (a_lo && !b_lo) begin
            b_hi_part = a_top - ADDR_W'(1);
        end else if (!a_lo && b_lo) begin
            b_hi_part = a_top + ADDR_W'(1);
        end
    end

    // Shift back into place; shift of 64 or more clears the upper part
    assign hi_shift = {1'b0, i_dec.exp} + (EXP_W+1)'(MANT_W);

    assign o_top  = (hi_shift[EXP_W] ? '0 : (t_hi_part << hi_shift[EXP_W-1:0]))
                  | (ADDR_W'(i_dec.top_mant) << i_dec.exp);
    assign o_base = (hi_shift[EXP_W] ? '0 : (b_hi_part << hi_shift[EXP_W-1:0]))
                  | (ADDR_W'(i_dec.base_mant) << i_dec.exp);

    // Access check, end address wraps modulo 2^64
    assign end_addr = i_addr + ADDR_W'(i_len);
    assign o_ok = (o_base <= i_addr) && (end_addr <= o_top)
               && (!i_wr || i_dec.perms[PERM_STORE_BIT])
               && (!i_rd || i_dec.perms[PERM_LOAD_BIT]);

endmodule

/* src/capability_bounds_decode_check_core.sv */
// Capability bounds decode and access check.
// Stages: input register, then result register; the decode and bounds check
// sit between the two.
// Throughput: one request per cycle, sustained while the result side takes.
// Reset: synchronous active-low i_rst_n clears both stage valid flags.
module capability_bounds_decode_check_core
    import cbdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [META_W-1:0]  i_compressed_meta,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic [LEN_W-1:0]   i_access_bytes,
    input  logic               i_wants_read,
    input  logic               i_wants_write,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ADDR_W-1:0]  o_bound_base,
    output logic [ADDR_W-1:0]  o_bound_top,
    output logic [OTYPE_W-1:0] o_object_type,
    output logic [PERM_W-1:0]  o_permissions,
    output logic [UPERM_W-1:0] o_user_permissions,
    output logic               o_access_allowed
);

    logic               r_in_valid;
    logic [META_W-1:0]  r_meta;
    logic [ADDR_W-1:0]  r_addr;
    logic [LEN_W-1:0]   r_len;
    logic               r_rd;
    logic               r_wr;

    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W-1:0]  r_top;
    logic [OTYPE_W-1:0] r_otype;
    logic [PERM_W-1:0]  r_perms;
    logic [UPERM_W-1:0] r_uperms;
    logic               r_ok;

    logic               n_in_valid;
    logic               n_out_valid;
    logic               advance;
    logic               take_in;

    t_dec               dec;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  top;
    logic               ok;

    // Pipeline flow: result register frees when empty or taken
    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;
    assign take_in = i_valid && o_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (take_in) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_meta <= i_compressed_meta;
            r_addr <= i_address;
            r_len  <= i_access_bytes;
            r_rd   <= i_wants_read;
            r_wr   <= i_wants_write;
        end
    end

    cbdc_decode u_decode (
        .i_meta (r_meta),
        .o_dec  (dec)
    );

    cbdc_bounds u_bounds (
        .i_dec  (dec),
        .i_addr (r_addr),
        .i_len  (r_len),
        .i_rd   (r_rd),
        .i_wr   (r_wr),
        .o_base (base),
        .o_top  (top),
        .o_ok   (ok)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_base   <= base;
            r_top    <= top;
            r_otype  <= dec.otype;
            r_perms  <= dec.perms;
            r_uperms <= dec.uperms;
            r_ok     <= ok;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_bound_base       = r_base;
    assign o_bound_top        = r_top;
    assign o_object_type      = r_otype;
    assign o_permissions      = r_perms;
    assign o_user_permissions = r_uperms;
    assign o_access_allowed   = r_ok;

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

    // An accepted request lands in the input stage
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_in |=> r_in_valid)
        else $error("accepted request lost at input stage");

    // A blocked input stage keeps its request
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_meta) && $stable(r_addr)))
        else $error("stalled input stage changed");

    // A request moving forward reaches the result register
    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> r_out_valid)
        else $error("request lost between stages");

endmodule
